/* rtl/cau_pkg.sv */
package cau_pkg;

  // default number of fraction bits of the fixed-point operands
  localparam int FRAC_BITS_DEF = 16;

  // quotient bits kept by the divider, enough to tell saturation apart
  localparam int QBITS = 33;
  localparam int DEN_W = 64;
  localparam int REM_W = DEN_W + QBITS;
  localparam int TOL_W = 31;

  typedef enum logic [2:0] {
    MODE_ADD       = 3'd0,
    MODE_SUB       = 3'd1,
    MODE_MUL       = 3'd2,
    MODE_CDIV      = 3'd3,
    MODE_RDIV      = 3'd4,
    MODE_APPROX_EQ = 3'd5,
    MODE_NOT_EQ    = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               compare_true;
    logic               div_by_zero;
    logic               overflow;
  } out_t;

  // what travels alongside the divider lanes
  typedef struct packed {
    out_t fix;
    logic is_div;
    logic neg_re;
    logic neg_im;
    logic sat_re;
    logic sat_im;
  } side_t;

  // saturate a 33-bit signed sum to 32 bits, overflow flag on top
  function automatic logic [32:0] sat33(input logic [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // sign and magnitude to saturated 32-bit value, overflow flag on top
  function automatic logic [32:0] pack(input logic neg, input logic huge,
                                       input logic [32:0] mag);
    logic [32:0] lim;
    logic [32:0] m;
    logic        ovf;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    ovf = huge || (mag > lim);
    m   = ovf ? lim : mag;
    return {ovf, (neg ? (32'd0 - m[31:0]) : m[31:0])};
  endfunction

endpackage

/* rtl/complex_arithmetic_unit_core.sv */
// Complex-number ALU on signed fixed-point operands (Q16.16 by default).
// Input channel in_valid/in_stall/in_item carries a mode and two complex
// operands; output channel out_valid/out_stall/out_item carries the result
// parts, the compare outcome and the divide-by-zero and overflow flags.
// An item is taken at a clock edge with valid high and stall low.
// The path from the accepting edge to out_valid runs through the input register,
// the product and sum stages, 33 divider stages (one quotient bit each, shared
// by all modes) and the output register. One item can enter every cycle unless the pipeline holds.
// When out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// The APB port holds equal_tolerance at address 0; writes are taken at
// psel & penable & pwrite whatever paddr, pready is always high.
// rst (synchronous, active high) empties the pipeline and sets the tolerance
// to 2^FRAC_BITS / 100.
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cau_pkg::in_t   in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output cau_pkg::out_t  out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int TOL_RST = (1 << FRAC_BITS) / 100;
  localparam int REM_W   = cau_pkg::REM_W;
  localparam int DEN_W   = cau_pkg::DEN_W;

  logic advance;
  logic [cau_pkg::TOL_W-1:0] tol;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {1'b0, tol} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= cau_pkg::TOL_W'(TOL_RST);
    end else if (psel && penable && pwrite) begin
      tol <= pwdata[cau_pkg::TOL_W-1:0];
    end
  end

  // whole pipeline moves unless a finished item is held
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage 1: input register
  logic          s1_v;
  cau_pkg::in_t  s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (advance) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= in_item;
    end
  end

  // stage 2: products, add/sub and compare results
  logic                s2_v;
  cau_pkg::in_t        s2;
  logic signed [63:0]  p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  cau_pkg::out_t       s2_fix, fix2_next;
  logic [32:0]         sum_re, sum_im, sat_re2, sat_im2;
  logic [32:0]         dif_re, dif_im, mag_dre, mag_dim;

  always_comb begin
    sum_re = (s1.mode == cau_pkg::MODE_SUB)
           ? {s1.a_re[31], s1.a_re} - {s1.b_re[31], s1.b_re}
           : {s1.a_re[31], s1.a_re} + {s1.b_re[31], s1.b_re};
    sum_im = (s1.mode == cau_pkg::MODE_SUB)
           ? {s1.a_im[31], s1.a_im} - {s1.b_im[31], s1.b_im}
           : {s1.a_im[31], s1.a_im} + {s1.b_im[31], s1.b_im};
    sat_re2 = cau_pkg::sat33(sum_re);
    sat_im2 = cau_pkg::sat33(sum_im);
    dif_re  = {s1.a_re[31], s1.a_re} - {s1.b_re[31], s1.b_re};
    dif_im  = {s1.a_im[31], s1.a_im} - {s1.b_im[31], s1.b_im};
    mag_dre = dif_re[32] ? 33'd0 - dif_re : dif_re;
    mag_dim = dif_im[32] ? 33'd0 - dif_im : dif_im;
    fix2_next = '0;
    case (s1.mode)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        fix2_next.res_re   = sat_re2[31:0];
        fix2_next.res_im   = sat_im2[31:0];
        fix2_next.overflow = sat_re2[32] | sat_im2[32];
      end
      cau_pkg::MODE_APPROX_EQ: begin
        fix2_next.compare_true = (mag_dre <= {2'b00, tol}) && (mag_dim <= {2'b00, tol});
      end
      cau_pkg::MODE_NOT_EQ: begin
        fix2_next.compare_true = (s1.a_re != s1.b_re) || (s1.a_im != s1.b_im);
      end
      default: begin
        fix2_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (advance) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2     <= s1;
      s2_fix <= fix2_next;
      p_rr   <= 64'($signed(s1.a_re)) * 64'($signed(s1.b_re));
      p_ii   <= 64'($signed(s1.a_im)) * 64'($signed(s1.b_im));
      p_ri   <= 64'($signed(s1.a_re)) * 64'($signed(s1.b_im));
      p_ir   <= 64'($signed(s1.a_im)) * 64'($signed(s1.b_re));
      sq_r   <= 64'($signed(s1.b_re)) * 64'($signed(s1.b_re));
      sq_i   <= 64'($signed(s1.b_im)) * 64'($signed(s1.b_im));
    end
  end

  // stage 3: sums of products, numerators and divisor
  logic              s3_v;
  cau_pkg::out_t     s3_fix, fix3_next;
  logic              s3_mul, s3_div, mul3_next, div3_next;
  logic              s3_neg_re, s3_neg_im, neg_re3, neg_im3;
  logic [63:0]       s3_num_re, s3_num_im, num_re3, num_im3;
  logic [DEN_W-1:0]  s3_den, den3;
  logic [64:0]       ps_re, ps_im;
  logic [64:0]       pm_re, pm_im;
  logic [32:0]       ar33, ai33, br33;
  logic              cdiv, zero_div;

  always_comb begin
    cdiv  = (s2.mode == cau_pkg::MODE_CDIV);
    ps_re = cdiv ? {p_rr[63], p_rr} + {p_ii[63], p_ii}
                 : {p_rr[63], p_rr} - {p_ii[63], p_ii};
    ps_im = cdiv ? {p_ir[63], p_ir} - {p_ri[63], p_ri}
                 : {p_ri[63], p_ri} + {p_ir[63], p_ir};
    pm_re = ps_re[64] ? 65'd0 - ps_re : ps_re;
    pm_im = ps_im[64] ? 65'd0 - ps_im : ps_im;
    ar33  = s2.a_re[31] ? 33'd0 - {1'b1, s2.a_re} : {1'b0, s2.a_re};
    ai33  = s2.a_im[31] ? 33'd0 - {1'b1, s2.a_im} : {1'b0, s2.a_im};
    br33  = s2.b_re[31] ? 33'd0 - {1'b1, s2.b_re} : {1'b0, s2.b_re};
    fix3_next = s2_fix;
    mul3_next = 1'b0;
    div3_next = 1'b0;
    zero_div  = 1'b0;
    neg_re3   = ps_re[64];
    neg_im3   = ps_im[64];
    num_re3   = pm_re[63:0];
    num_im3   = pm_im[63:0];
    den3      = DEN_W'(sq_r) + DEN_W'(sq_i);
    case (s2.mode)
      cau_pkg::MODE_MUL: begin
        mul3_next = 1'b1;
      end
      cau_pkg::MODE_CDIV: begin
        zero_div  = (s2.b_re == 32'sd0) && (s2.b_im == 32'sd0);
        div3_next = !zero_div;
      end
      cau_pkg::MODE_RDIV: begin
        zero_div  = (s2.b_re == 32'sd0);
        div3_next = !zero_div;
        neg_re3   = s2.a_re[31] != s2.b_re[31];
        neg_im3   = s2.a_im[31] != s2.b_re[31];
        num_re3   = 64'(ar33);
        num_im3   = 64'(ai33);
        den3      = DEN_W'(br33);
      end
      default: begin
        mul3_next = 1'b0;
      end
    endcase
    if (zero_div) begin
      fix3_next             = '0;
      fix3_next.div_by_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (advance) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_fix    <= fix3_next;
      s3_mul    <= mul3_next;
      s3_div    <= div3_next;
      s3_neg_re <= neg_re3;
      s3_neg_im <= neg_im3;
      s3_num_re <= num_re3;
      s3_num_im <= num_im3;
      s3_den    <= den3;
    end
  end

  // product packing and divider set-up
  cau_pkg::side_t    side_in;
  logic [REM_W-1:0]  rem_re0, rem_im0, den_top;
  logic [63:0]       mq_re, mq_im;
  logic [32:0]       pk_re, pk_im;

  always_comb begin
    rem_re0 = REM_W'(s3_num_re) << FRAC_BITS;
    rem_im0 = REM_W'(s3_num_im) << FRAC_BITS;
    den_top = REM_W'(s3_den) << cau_pkg::QBITS;
    mq_re   = s3_num_re >> FRAC_BITS;
    mq_im   = s3_num_im >> FRAC_BITS;
    pk_re   = cau_pkg::pack(s3_neg_re, |mq_re[63:33], mq_re[32:0]);
    pk_im   = cau_pkg::pack(s3_neg_im, |mq_im[63:33], mq_im[32:0]);
    side_in        = '0;
    side_in.fix    = s3_fix;
    side_in.is_div = s3_div;
    side_in.neg_re = s3_neg_re;
    side_in.neg_im = s3_neg_im;
    side_in.sat_re = rem_re0 >= den_top;
    side_in.sat_im = rem_im0 >= den_top;
    if (s3_mul) begin
      side_in.fix          = '0;
      side_in.fix.res_re   = pk_re[31:0];
      side_in.fix.res_im   = pk_im[31:0];
      side_in.fix.overflow = pk_re[32] | pk_im[32];
    end
  end

  logic                       dv_v;
  logic [cau_pkg::QBITS-1:0]  dq_re, dq_im;
  cau_pkg::side_t             dside;

  cau_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s3_v),
    .in_den    (s3_den),
    .in_rem_re (rem_re0),
    .in_rem_im (rem_im0),
    .in_side   (side_in),
    .out_valid (dv_v),
    .out_q_re  (dq_re),
    .out_q_im  (dq_im),
    .out_side  (dside)
  );

  // output register: quotient packing, or the other results passed through
  cau_pkg::out_t  out_next;
  logic [32:0]    fq_re, fq_im;

  always_comb begin
    fq_re = cau_pkg::pack(dside.neg_re, dside.sat_re, dq_re);
    fq_im = cau_pkg::pack(dside.neg_im, dside.sat_im, dq_im);
    if (dside.is_div) begin
      out_next          = '0;
      out_next.res_re   = fq_re[31:0];
      out_next.res_im   = fq_im[31:0];
      out_next.overflow = fq_re[32] | fq_im[32];
    end else begin
      out_next = dside.fix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= out_next;
    end
  end

`ifndef ASSERT_OFF
  // a zero divisor gives zero parts and no overflow
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.div_by_zero |->
      out_item.res_re == 32'sd0 && out_item.res_im == 32'sd0 && !out_item.overflow)
    else $error("divide by zero with nonzero result");

  // compare outcome never comes with arithmetic flags
  a_cmp_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.compare_true |-> !out_item.overflow && !out_item.div_by_zero)
    else $error("compare result mixed with arithmetic flags");

  // overflow means at least one part sits at a limit
  a_ovf_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |->
      out_item.res_re == 32'sh7FFF_FFFF || out_item.res_re == 32'sh8000_0000 ||
      out_item.res_im == 32'sh7FFF_FFFF || out_item.res_im == 32'sh8000_0000)
    else $error("overflow without saturated part");

  // a held item stays valid while the pipeline is frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> out_valid)
    else $error("held item dropped");
`endif

endmodule

/* rtl/cau_divider.sv */
module cau_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [cau_pkg::DEN_W-1:0]    in_den,
  input  logic [cau_pkg::REM_W-1:0]    in_rem_re,
  input  logic [cau_pkg::REM_W-1:0]    in_rem_im,
  input  cau_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [cau_pkg::QBITS-1:0]    out_q_re,
  output logic [cau_pkg::QBITS-1:0]    out_q_im,
  output cau_pkg::side_t               out_side
);

  localparam int QB = cau_pkg::QBITS;

  // one restoring step per stage, both lanes share the divisor
  logic                        v      [QB];
  logic [cau_pkg::DEN_W-1:0]   den    [QB];
  logic [cau_pkg::REM_W-1:0]   rem_re [QB];
  logic [cau_pkg::REM_W-1:0]   rem_im [QB];
  logic [QB-1:0]               q_re   [QB];
  logic [QB-1:0]               q_im   [QB];
  cau_pkg::side_t              side   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic                      pv;
    logic [cau_pkg::DEN_W-1:0] pden;
    logic [cau_pkg::REM_W-1:0] pre, pim, trial;
    logic [QB-1:0]             pqre, pqim;
    cau_pkg::side_t            pside;
    logic                      ge_re, ge_im;

    if (k == 0) begin : g_first
      always_comb begin
        pv    = in_valid;
        pden  = in_den;
        pre   = in_rem_re;
        pim   = in_rem_im;
        pqre  = '0;
        pqim  = '0;
        pside = in_side;
      end
    end else begin : g_next
      always_comb begin
        pv    = v[k-1];
        pden  = den[k-1];
        pre   = rem_re[k-1];
        pim   = rem_im[k-1];
        pqre  = q_re[k-1];
        pqim  = q_im[k-1];
        pside = side[k-1];
      end
    end

    // trial subtract of the shifted divisor
    always_comb begin
      trial = cau_pkg::REM_W'(pden) << B;
      ge_re = pre >= trial;
      ge_im = pim >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[k]    <= pden;
        side[k]   <= pside;
        rem_re[k] <= ge_re ? pre - trial : pre;
        rem_im[k] <= ge_im ? pim - trial : pim;
        q_re[k]   <= pqre | (QB'(ge_re) << B);
        q_im[k]   <= pqim | (QB'(ge_im) << B);
      end
    end
  end

  assign out_valid = v[QB-1];
  assign out_q_re  = q_re[QB-1];
  assign out_q_im  = q_im[QB-1];
  assign out_side  = side[QB-1];

endmodule
